// ----- hdl/pdec_pkg.sv -----
// Shared types, character constants and hex helpers for the percent-escape decoder.
// No dependencies; every other file refers to this package by scoped names.

package pdec_pkg;

  localparam logic [7:0] PCT_CHAR     = 8'h25;  // '%'
  localparam logic [7:0] DIGIT_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_NINE   = 8'h39;  // '9'
  localparam logic [7:0] UPPER_A      = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_F      = 8'h46;  // 'F'
  localparam logic [7:0] LOWER_A      = 8'h61;  // 'a'
  localparam logic [7:0] LOWER_F      = 8'h66;  // 'f'
  localparam logic [7:0] UPPER_OFFSET = 8'h37;  // 'A' - 10
  localparam logic [7:0] LOWER_OFFSET = 8'h57;  // 'a' - 10

  localparam int unsigned MAX_RESULTS = 3;

  // One input character with its end-of-string flag.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  // Up to three decoded characters caused by one input character.
  typedef struct packed {
    logic [1:0]                   count;
    logic [MAX_RESULTS-1:0][7:0]  bytes;     // bytes[0] goes out first
    logic                         str_last;
  } group_t;

  typedef enum logic [3:0] {
    PH_NORMAL   = 4'b0001,
    PH_PCT      = 4'b0010,
    PH_HIGH_OK  = 4'b0100,
    PH_HIGH_BAD = 4'b1000
  } phase_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= DIGIT_ZERO) && (c <= DIGIT_NINE)) ||
        ((c >= UPPER_A) && (c <= UPPER_F)) ||
        ((c >= LOWER_A) && (c <= LOWER_F));
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if ((c >= DIGIT_ZERO) && (c <= DIGIT_NINE)) begin
      d = c - DIGIT_ZERO;
    end else if ((c >= UPPER_A) && (c <= UPPER_F)) begin
      d = c - UPPER_OFFSET;
    end else if ((c >= LOWER_A) && (c <= LOWER_F)) begin
      d = c - LOWER_OFFSET;
    end else begin
      d = 8'h00;
    end
    return d[3:0];
  endfunction

endpackage

// ----- hdl/pdec_skid.sv -----
// Input skid buffer: registers the incoming word and keeps tready registered.
// Depends on pdec_pkg for the item type.

module pdec_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pdec_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output pdec_pkg::item_t out_item
);

  logic            skid_valid;
  pdec_pkg::item_t skid_item;
  logic            in_acc;

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_item  <= in_item;
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      // park the word while the output side is stalled
      skid_item  <= in_item;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ----- hdl/pdec_decode.sv -----
// Escape phase tracker: turns one input character into zero to three output bytes.
// Depends on pdec_pkg for types, constants and hex helpers.

module pdec_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  pdec_pkg::item_t  item,
  output pdec_pkg::group_t grp
);

  pdec_pkg::phase_t phase, phase_next;
  logic [7:0]       held, held_next;

  always_comb begin
    phase_next   = phase;
    held_next    = held;
    grp.count    = 2'd0;
    grp.bytes    = '0;
    grp.str_last = item.last;
    case (phase)
      pdec_pkg::PH_NORMAL: begin
        if ((item.ch == pdec_pkg::PCT_CHAR) && !item.last) begin
          phase_next = pdec_pkg::PH_PCT;
        end else begin
          grp.count    = 2'd1;
          grp.bytes[0] = item.ch;
        end
      end
      pdec_pkg::PH_PCT: begin
        if (item.last) begin
          grp.count    = 2'd2;
          grp.bytes[0] = pdec_pkg::PCT_CHAR;
          grp.bytes[1] = item.ch;
        end else begin
          held_next  = item.ch;
          phase_next = pdec_pkg::is_hex(item.ch) ? pdec_pkg::PH_HIGH_OK
                                                 : pdec_pkg::PH_HIGH_BAD;
        end
      end
      pdec_pkg::PH_HIGH_OK: begin
        // held digit is known good here; only the second one needs a check
        if (pdec_pkg::is_hex(item.ch)) begin
          grp.count    = 2'd1;
          grp.bytes[0] = {pdec_pkg::hex_val(held), pdec_pkg::hex_val(item.ch)};
        end else begin
          grp.count    = 2'd3;
          grp.bytes[0] = pdec_pkg::PCT_CHAR;
          grp.bytes[1] = held;
          grp.bytes[2] = item.ch;
        end
        phase_next = pdec_pkg::PH_NORMAL;
        held_next  = 8'h00;
      end
      default: begin
        grp.count    = 2'd3;
        grp.bytes[0] = pdec_pkg::PCT_CHAR;
        grp.bytes[1] = held;
        grp.bytes[2] = item.ch;
        phase_next   = pdec_pkg::PH_NORMAL;
        held_next    = 8'h00;
      end
    endcase
    if (item.last) begin
      phase_next = pdec_pkg::PH_NORMAL;
      held_next  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pdec_pkg::PH_NORMAL;
      held  <= 8'h00;
    end else if (fire) begin
      phase <= phase_next;
      held  <= held_next;
    end
  end

endmodule

// ----- hdl/pdec_emit.sv -----
// Output buffer: holds one decoded group and sends it out one word per cycle while out_ready is high.
// Depends on pdec_pkg for the group type.

module pdec_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             grp_valid,
  output logic             take,
  input  pdec_pkg::group_t grp,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             string_last
);

  logic [pdec_pkg::MAX_RESULTS-1:0][7:0] buf_bytes;
  logic [1:0]                            cnt;
  logic                                  slast;
  logic                                  out_acc;

  assign out_valid   = (cnt != 2'd0);
  assign out_acc     = out_valid && out_ready;
  assign take        = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);
  assign out_byte    = buf_bytes[0];
  assign run_last    = (cnt == 2'd1);
  assign string_last = (cnt == 2'd1) && slast;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (take && grp_valid) begin
      cnt       <= grp.count;
      buf_bytes <= grp.bytes;
      slast     <= grp.str_last;
    end else if (out_acc) begin
      // advance to the next pending byte
      cnt          <= cnt - 2'd1;
      buf_bytes[0] <= buf_bytes[1];
      buf_bytes[1] <= buf_bytes[2];
    end
  end

endmodule

// ----- hdl/percent_escape_decoder_core.sv -----
// Percent-escape decoder top level: input skid buffer, escape decoder, output buffer.
// Depends on pdec_pkg, pdec_skid, pdec_decode and pdec_emit.

// Decodes URL percent escapes in a byte stream, one character per word with tlast
// on the final character of each string. "%hh" with hex digits of either case
// becomes one byte; malformed or truncated escapes pass through verbatim. Each
// output word carries one decoded byte, tuser[0] marks the last byte caused by
// an input word and tlast the final byte of the string. While the output is not
// stalled, the block sustains one word per clock for words that yield zero or
// one byte; a word that yields two or three bytes (a bad escape or one cut
// short by the string end) holds the input until its last byte is sent, as
// the output buffer sends one byte per cycle while m_axis_tready is high.

module percent_escape_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // string_last
  output logic [0:0] m_axis_tuser    // [0] run_last
);

  pdec_pkg::item_t  in_item, dec_item;
  pdec_pkg::group_t grp;
  logic             dec_valid;
  logic             take;
  logic             fire;
  logic             run_last;

  assign in_item.ch   = s_axis_tdata;
  assign in_item.last = s_axis_tlast;
  assign fire         = dec_valid && take;
  assign m_axis_tuser = run_last;

  pdec_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (dec_valid),
    .out_ready (take),
    .out_item  (dec_item)
  );

  pdec_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (dec_item),
    .grp  (grp)
  );

  pdec_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .grp_valid   (dec_valid),
    .take        (take),
    .grp         (grp),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .run_last    (run_last),
    .string_last (m_axis_tlast)
  );

  // A full skid buffer always has a word waiting at the decoder.
  a_skid_full_has_word: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> dec_valid)
    else $error("skid full without a pending word");

  // The end-of-string byte is always the last of its group.
  a_string_last_run_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("string end not on last byte of group");

  // A stalled output group of any size keeps the decoder from taking a new word.
  a_stall_blocks_decode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !fire)
    else $error("decoder fired while output stalled");

  // A byte not marked as end of group is followed by another valid byte.
  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=> m_axis_tvalid)
    else $error("group ended early");

endmodule
